>>> rtl/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
`default_nettype none
package lir_pkg;

  localparam int PH_FRAC_BITS = 16;
  localparam int PH_W         = 19;
  localparam int SMP_W        = 16;
  localparam int CNT_W        = 6;
  localparam int PROD_W       = SMP_W + 1 + PH_FRAC_BITS + 1;

  localparam logic [PH_W-1:0]  PH_ONE      = PH_W'(1) << PH_FRAC_BITS;
  localparam logic [PH_W-1:0]  STEP_MIN    = PH_ONE >> 6;
  localparam logic [PH_W-1:0]  STEP_MAX    = PH_ONE << 2;
  localparam logic [PH_W-1:0]  STEP_RESET  = PH_ONE;
  localparam logic [CNT_W-1:0] CNT_LAST    = {CNT_W{1'b1}};

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    restart;
  } in_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] out_sample;
    logic                    last_of_run;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic advance;
  } ctl_t;

  typedef struct packed {
    logic skip;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/lir_dp.sv
// Datapath: phase and sample state plus the shared multiply unit.
`default_nettype none
module lir_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lir_pkg::ctl_t             ctl,
  input  wire lir_pkg::in_word_t         in_data,
  input  wire logic [lir_pkg::PH_W-1:0]  step_reg,
  output lir_pkg::sts_t                  sts,
  output lir_pkg::out_word_t             out_data
);

  logic signed [lir_pkg::SMP_W-1:0]  prev;
  logic signed [lir_pkg::SMP_W-1:0]  cur;
  logic signed [lir_pkg::SMP_W-1:0]  base;
  logic        [lir_pkg::PH_W-1:0]   phase;
  logic        [lir_pkg::CNT_W-1:0]  count;
  logic signed [lir_pkg::PROD_W-1:0] prod;
  logic                              last;

  logic        [lir_pkg::PH_W-1:0]   step_c;
  logic        [lir_pkg::PH_W-1:0]   phase0;
  logic signed [lir_pkg::SMP_W-1:0]  prev0;
  logic        [lir_pkg::PH_W-1:0]   phase_next;
  logic signed [lir_pkg::SMP_W:0]    diff;
  logic signed [lir_pkg::PROD_W-1:0] total;
  logic signed [lir_pkg::PROD_W-1:0] quot;

  always_comb begin
    if (step_reg < lir_pkg::STEP_MIN) begin
      step_c = lir_pkg::STEP_MIN;
    end else if (step_reg > lir_pkg::STEP_MAX) begin
      step_c = lir_pkg::STEP_MAX;
    end else begin
      step_c = step_reg;
    end
  end

  assign phase0     = in_data.restart ? '0 : phase;
  assign prev0      = in_data.restart ? '0 : prev;
  assign phase_next = phase + step_c;
  assign diff       = (lir_pkg::SMP_W+1)'(cur) - (lir_pkg::SMP_W+1)'(prev);

  assign sts.skip = phase0 >= lir_pkg::PH_ONE;
  assign sts.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      phase <= '0;
    end else if (ctl.load) begin
      if (sts.skip) begin
        phase <= phase0 - lir_pkg::PH_ONE;
        prev  <= in_data.sample;
      end else begin
        phase <= phase0;
        prev  <= prev0;
      end
    end else if (ctl.advance) begin
      if (last) begin
        prev  <= cur;
        phase <= (phase_next >= lir_pkg::PH_ONE) ? phase_next - lir_pkg::PH_ONE : '0;
      end else begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur   <= in_data.sample;
      count <= '0;
    end else if (ctl.advance) begin
      count <= count + 1'b1;
    end
    if (ctl.mul) begin
      prod <= lir_pkg::PROD_W'(diff) *
              lir_pkg::PROD_W'($signed({1'b0, phase[lir_pkg::PH_FRAC_BITS-1:0]}));
      base <= prev;
      last <= (phase_next >= lir_pkg::PH_ONE) || (count == lir_pkg::CNT_LAST);
    end
  end

  // prev*ONE + diff*phase, then divide by ONE truncating toward zero
  assign total = (lir_pkg::PROD_W'(base) <<< lir_pkg::PH_FRAC_BITS) + prod;

  always_comb begin
    quot = total >>> lir_pkg::PH_FRAC_BITS;
    if (total[lir_pkg::PROD_W-1] && (total[lir_pkg::PH_FRAC_BITS-1:0] != '0)) begin
      quot = quot + lir_pkg::PROD_W'(1);
    end
  end

  assign out_data.out_sample  = quot[lir_pkg::SMP_W-1:0];
  assign out_data.last_of_run = last;

endmodule
`default_nettype wire

>>> rtl/lir_ctrl.sv
// Sequencer: accepts a word, then multiplies and emits one result at a time.
`default_nettype none
module lir_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          out_stall,
  input  wire lir_pkg::sts_t sts,
  output lir_pkg::ctl_t      ctl,
  output logic               in_stall,
  output logic               out_valid
);

  lir_pkg::state_t state;
  lir_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lir_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lir_pkg::ST_IDLE: begin
        if (in_valid && !sts.skip) begin
          state_next = lir_pkg::ST_MUL;
        end
      end
      lir_pkg::ST_MUL: begin
        state_next = lir_pkg::ST_EMIT;
      end
      lir_pkg::ST_EMIT: begin
        if (!out_stall) begin
          state_next = sts.last ? lir_pkg::ST_IDLE : lir_pkg::ST_MUL;
        end
      end
      default: begin
        state_next = lir_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      lir_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      lir_pkg::ST_MUL: begin
        ctl.mul = 1'b1;
      end
      lir_pkg::ST_EMIT: begin
        out_valid   = 1'b1;
        ctl.advance = !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/linear_interp_audio_resampler.sv
// Linear interpolation audio resampler: top level.
//
// Input channel in_valid/in_stall/in_data carries one source sample word with
// a restart flag; output channel out_valid/out_stall/out_data carries the
// interpolated samples, the last one of each input flagged by last_of_run.
// A word is taken when valid is high and stall is low.
// cfg_wr_en/cfg_wr_data write the step register (source/output rate, Q16);
// write it only while the block is idle. Steps outside 1/64..4 are clamped.
// One input gives 0 to 64 results. Each result, the first one after the
// input is taken and each further one after the previous one is taken,
// passes the multiply state (shared multiplier) and then the emit state.
// An input that gives no result leaves the block idle; one giving results
// occupies the block until its last result is taken, stall time included.
// in_stall is high while results of the current input are outstanding.
// A stalled output holds its word and freezes the sequencer.
// Reset (rst, synchronous) clears previous sample and phase to zero and
// the step to one.
`default_nettype none
module linear_interp_audio_resampler (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire lir_pkg::in_word_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output lir_pkg::out_word_t             out_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [lir_pkg::PH_W-1:0]  cfg_wr_data
);

  logic [lir_pkg::PH_W-1:0] step_reg;
  lir_pkg::ctl_t            ctl;
  lir_pkg::sts_t            sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg <= lir_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      step_reg <= cfg_wr_data;
    end
  end

  lir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  lir_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_data  (in_data),
    .step_reg (step_reg),
    .sts      (sts),
    .out_data (out_data)
  );

  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_mul_before_emit: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown before multiply");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last_of_run) |=> in_stall)
    else $error("input ready before run ended");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_of_run) |=> (!out_valid && !in_stall))
    else $error("block not idle after last result");

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the linear interpolation audio resampler.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN  = 64;
  localparam int HOLD_LEN = 400;
  localparam int WATCHDOG = 2000;
  localparam int PER_PHASE = 15;

  class interp_tracker;
    logic [lir_pkg::PH_W-1:0]         step_reg;
    logic signed [lir_pkg::SMP_W-1:0] prev;
    logic [lir_pkg::PH_W-1:0]         phase;
    lir_pkg::out_word_t               pending_outs[$];
    int                               errors;

    function new();
      step_reg = lir_pkg::STEP_RESET;
      prev     = '0;
      phase    = '0;
      errors   = 0;
    endfunction

    function void set_step(logic [lir_pkg::PH_W-1:0] v);
      step_reg = v;
    endfunction

    function bit busy();
      return pending_outs.size() != 0;
    endfunction

    function void take_sample(lir_pkg::in_word_t w);
      logic [lir_pkg::PH_W-1:0] stp;
      logic [lir_pkg::PH_W-1:0] nxt;
      longint                   span;
      longint                   acc;
      int                       n;
      lir_pkg::out_word_t       o;
      stp = (step_reg < lir_pkg::STEP_MIN) ? lir_pkg::STEP_MIN :
            (step_reg > lir_pkg::STEP_MAX) ? lir_pkg::STEP_MAX : step_reg;
      if (w.restart) begin
        prev  = '0;
        phase = '0;
      end
      span = longint'(w.sample) - longint'(prev);
      n = 0;
      while (phase < lir_pkg::PH_ONE && n < MAX_RUN) begin
        acc = longint'(prev) * longint'(lir_pkg::PH_ONE) + span * longint'(phase);
        nxt = phase + stp;
        o.out_sample  = 16'(acc / longint'(lir_pkg::PH_ONE));
        o.last_of_run = (nxt >= lir_pkg::PH_ONE) || (n + 1 == MAX_RUN);
        pending_outs.push_back(o);
        n++;
        phase = nxt;
      end
      if (phase >= lir_pkg::PH_ONE) begin
        phase = phase - lir_pkg::PH_ONE;
      end else begin
        phase = '0;
      end
      prev = w.sample;
    endfunction

    function void check_output(lir_pkg::out_word_t got);
      lir_pkg::out_word_t want;
      if (pending_outs.size() == 0) begin
        $display("%0t: unexpected word: sample %0d last %0b", $time, got.out_sample,
                 got.last_of_run);
        errors++;
        return;
      end
      want = pending_outs.pop_front();
      if (got.out_sample !== want.out_sample) begin
        $display("%0t: out_sample expected %0d actual %0d", $time, want.out_sample,
                 got.out_sample);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, want.last_of_run,
                 got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  lir_pkg::in_word_t        in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  lir_pkg::out_word_t       out_data;
  logic                     cfg_wr_en = 1'b0;
  logic [lir_pkg::PH_W-1:0] cfg_wr_data = '0;

  int send_pct  = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  interp_tracker sb = new();

  linear_interp_audio_resampler DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stall plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    logic in_acc;
    logic out_acc;
    in_acc  = !rst && in_valid && (in_stall === 1'b0);
    out_acc = !rst && (out_valid === 1'b1) && !out_stall;
    if (in_acc) begin
      sb.take_sample(in_data);
    end
    if (out_acc) begin
      sb.check_output(out_data);
    end
    if (in_acc || out_acc) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic offer_sample(input logic rs, input logic [lir_pkg::SMP_W-1:0] s);
    lir_pkg::in_word_t w;
    w.sample  = s;
    w.restart = rs;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // wait until every expected word has come, plus the no-result latency
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.busy()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_step(input logic [lir_pkg::PH_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_step(v);
  endtask

  initial begin
    logic [lir_pkg::PH_W-1:0]  steps[9];
    logic                      rs;
    logic [lir_pkg::SMP_W-1:0] s;
    int                        pick;
    steps = '{19'd60211, 19'd1024, 19'd0, 19'd262144, 19'd524287, 19'd0, 19'd0,
              19'd71347, 19'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step at its reset value of one
    offer_sample(1'b1, 16'h7fff);
    offer_sample(1'b0, 16'h8000);
    offer_sample(1'b0, 16'h8000);
    offer_sample(1'b0, 16'h7fff);
    offer_sample(1'b0, 16'h0000);
    offer_sample(1'b0, 16'hffff);
    settle();
    // fractional step, negative values truncate toward zero
    load_step(19'd43690);
    offer_sample(1'b1, -16'sd3);
    offer_sample(1'b0, 16'sd5);
    offer_sample(1'b0, 16'h8000);
    settle();
    load_step(lir_pkg::STEP_MIN);
    offer_sample(1'b1, 16'h7fff);
    offer_sample(1'b0, 16'h8000);
    settle();
    // phase at or above one: inputs with no output
    load_step(lir_pkg::STEP_MAX);
    offer_sample(1'b1, 16'sd100);
    offer_sample(1'b0, -16'sd100);
    offer_sample(1'b0, 16'sd7);
    offer_sample(1'b0, 16'h8000);
    offer_sample(1'b0, 16'h7fff);
    settle();
    // steps out of range are clamped
    load_step(19'd0);
    offer_sample(1'b1, 16'sd1000);
    offer_sample(1'b0, -16'sd1000);
    settle();
    load_step(19'h7ffff);
    offer_sample(1'b1, -16'sd5);
    offer_sample(1'b0, 16'sd5);
    offer_sample(1'b0, 16'sd6);
    settle();
    load_step(lir_pkg::STEP_MIN - 1);
    offer_sample(1'b0, 16'sd1);
    settle();
    load_step(lir_pkg::STEP_MAX + 1);
    offer_sample(1'b0, 16'sd2);
    offer_sample(1'b0, 16'sd3);
    settle();

    for (int p = 0; p < 9; p++) begin
      if (p == 2 || p == 5 || p == 8) begin
        steps[p] = 19'($urandom_range(262144, 1024));
      end
      if (p == 6) begin
        steps[p] = 19'($urandom_range(1023));
      end
      load_step(steps[p]);
      case (p % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 56; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 56; end
        default: begin send_pct = 17; stall_pct = 17; end
      endcase
      for (int i = 0; i < PER_PHASE; i++) begin
        if (p == 0 && i == 2) begin
          hold_reqs <= hold_reqs + 1;
        end
        if (p == 3 && i == 9) begin
          settle();
        end
        rs = ($urandom_range(9) == 0);
        pick = $urandom_range(9);
        s = (pick == 0) ? 16'h7fff : (pick == 1) ? 16'h8000 : 16'($urandom);
        offer_sample(rs, s);
      end
      settle();
    end

    send_pct = 0;
    stall_pct = 0;
    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/lir_pkg.sv
rtl/lir_dp.sv
rtl/lir_ctrl.sv
rtl/linear_interp_audio_resampler.sv
tb/testbench.sv
